// ===== rtl/bbw_pkg.sv =====
// Package for the blitter word datapath: field widths, codes and shared types.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package bbw_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned BufW    = 32;
  localparam int unsigned LineW   = 4;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned HtDepth = 16;

  // Item op codes; 5 to 7 are unused and change nothing
  typedef enum logic [OpW-1:0] {
    OP_LOAD_HT  = 3'd0,
    OP_RESTART  = 3'd1,
    OP_SRC      = 3'd2,
    OP_DEST     = 3'd3,
    OP_END_LINE = 3'd4
  } op_e;

  typedef enum logic [PosW-1:0] {
    POS_FIRST  = 2'd0,
    POS_MIDDLE = 2'd1,
    POS_LAST   = 2'd2
  } pos_e;

  typedef enum logic [1:0] {
    HOP_ONES   = 2'd0,
    HOP_HT     = 2'd1,
    HOP_SRC    = 2'd2,
    HOP_SRC_HT = 2'd3
  } hop_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOGIC_OP    = 3'd0,
    REG_HT_OP       = 3'd1,
    REG_SKEW        = 3'd2,
    REG_MODE        = 3'd3,
    REG_START_LINE  = 3'd4,
    REG_MASK_FIRST  = 3'd5,
    REG_MASK_MIDDLE = 3'd6,
    REG_MASK_LAST   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]       logic_op;
    logic [1:0]       halftone_op;
    logic [3:0]       skew_amount;
    logic             mode_ht_dec;
    logic             mode_src_rev;
    logic             mode_smudge;
    logic [LineW-1:0] start_line;
    logic [DataW-1:0] mask_first;
    logic [DataW-1:0] mask_middle;
    logic [DataW-1:0] mask_last;
  } cfg_t;

  typedef struct packed {
    logic               strobe;
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   data;
  } cfg_wr_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [PosW-1:0]  position;
    logic [DataW-1:0] data_word;
    logic [IdxW-1:0]  table_index;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } commit_t;

  typedef logic [HtDepth-1:0][DataW-1:0] ht_table_t;

endpackage

// ===== rtl/bbw_if.sv =====
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on bbw_pkg.
`timescale 1ns / 1ps

interface bbw_in_if import bbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [PosW-1:0]  position;
  logic [DataW-1:0] data_word;
  logic [IdxW-1:0]  table_index;

  modport source (output valid, op, position, data_word, table_index, input ready);
  modport sink   (input valid, op, position, data_word, table_index, output ready);
endinterface

interface bbw_out_if import bbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result_word;
  logic [LineW-1:0] line_index;

  modport source (output valid, result_word, line_index, input ready);
  modport sink   (input valid, result_word, line_index, output ready);
endinterface

interface bbw_cfg_if import bbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bitblit_word_logic_datapath_top.sv =====
// Top level of the blitter word datapath: input register, combine, result register.
// Depends on bbw_pkg, bbw_if, bbw_cfg_regs, bbw_state, bbw_combine.
//
//   channel  dir  transfer when     payload
//   cfg_i    in   valid && ready    index, data (ready always high)
//   in_i     in   valid && ready    op, position, data_word, table_index
//   out_o    out  valid && ready    result_word, line_index
//
// One item per cycle sustained while the result is not stalled.
// The input register feeds the combine logic, which writes the result register
// and updates the state in the same edge, so back-to-back items see fresh state.
// A stalled result holds; one more item waits in the input register meanwhile.
// Reset clears the control state and the state and sets config defaults; data registers are not reset.
`timescale 1ns / 1ps

module bitblit_word_logic_datapath_top import bbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbw_cfg_if.sink   cfg_i,
  bbw_in_if.sink    in_i,
  bbw_out_if.source out_o
);

  cfg_t             cfg;
  cfg_wr_t          cfg_wr;
  commit_t          commit;
  ht_table_t        ht_table;
  logic [BufW-1:0]  src_buf;
  logic [LineW-1:0] cur_line, line_next;
  logic [DataW-1:0] comb_result;

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             out_valid_q;
  logic [DataW-1:0] result_q;
  logic [LineW-1:0] line_q;
  logic             move, in_ready, accept;

  assign cfg_i.ready   = 1'b1;
  assign cfg_wr.strobe = cfg_i.valid;
  assign cfg_wr.index  = cfg_i.index;
  assign cfg_wr.data   = cfg_i.data;

  assign move     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || move;
  assign accept   = in_i.valid && in_ready;

  assign commit.valid = move;
  assign commit.item  = s1_item_q;

  bbw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .cfg_o  (cfg)
  );

  bbw_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .commit_i    (commit),
    .table_o     (ht_table),
    .src_buf_o   (src_buf),
    .line_o      (cur_line),
    .line_next_o (line_next)
  );

  bbw_combine u_combine (
    .cfg_i     (cfg),
    .item_i    (s1_item_q),
    .table_i   (ht_table),
    .src_buf_i (src_buf),
    .line_i    (cur_line),
    .result_o  (comb_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.op          <= in_i.op;
      s1_item_q.position    <= in_i.position;
      s1_item_q.data_word   <= in_i.data_word;
      s1_item_q.table_index <= in_i.table_index;
    end
    if (move) begin
      result_q <= comb_result;
      line_q   <= line_next;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_word = result_q;
  assign out_o.line_index  = line_q;

  // reported line matches the state line right after a commit
  a_line_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (line_q == cur_line))
    else $error("result line index differs from state line");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken with both stages full and result stalled");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && s1_item_q.op == OP_RESTART) |=> (cur_line == $past(cfg.start_line)))
    else $error("restart did not load start line");

  a_non_dest_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && s1_item_q.op != OP_DEST) |=> (result_q == '0))
    else $error("non-destination item gave non-zero word");

endmodule

// ===== rtl/bbw_cfg_regs.sv =====
// Configuration register file of the blitter word datapath.
// Depends on bbw_pkg.
`timescale 1ns / 1ps

module bbw_cfg_regs import bbw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t wr_i,
  output cfg_t    cfg_o
);

  // end masks come out of reset fully open, everything else clear
  localparam cfg_t CfgReset = '{
    logic_op:     '0,
    halftone_op:  '0,
    skew_amount:  '0,
    mode_ht_dec:  1'b0,
    mode_src_rev: 1'b0,
    mode_smudge:  1'b0,
    start_line:   '0,
    mask_first:   '1,
    mask_middle:  '1,
    mask_last:    '1
  };

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i.strobe) begin
      unique case (cfg_reg_e'(wr_i.index))
        REG_LOGIC_OP:    cfg_d.logic_op    = wr_i.data[3:0];
        REG_HT_OP:       cfg_d.halftone_op = wr_i.data[1:0];
        REG_SKEW:        cfg_d.skew_amount = wr_i.data[3:0];
        REG_MODE: begin
          cfg_d.mode_smudge  = wr_i.data[0];
          cfg_d.mode_src_rev = wr_i.data[1];
          cfg_d.mode_ht_dec  = wr_i.data[2];
        end
        REG_START_LINE:  cfg_d.start_line  = wr_i.data[LineW-1:0];
        REG_MASK_FIRST:  cfg_d.mask_first  = wr_i.data;
        REG_MASK_MIDDLE: cfg_d.mask_middle = wr_i.data;
        REG_MASK_LAST:   cfg_d.mask_last   = wr_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bbw_state.sv =====
// Datapath state: halftone table, 32-bit source buffer and halftone line index.
// Updated when an item commits to the result register. Depends on bbw_pkg.
`timescale 1ns / 1ps

module bbw_state import bbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  commit_t          commit_i,
  output ht_table_t        table_o,
  output logic [BufW-1:0]  src_buf_o,
  output logic [LineW-1:0] line_o,
  output logic [LineW-1:0] line_next_o
);

  ht_table_t        table_q;
  logic [BufW-1:0]  src_buf_q, src_buf_d;
  logic [LineW-1:0] line_q, line_d;

  always_comb begin
    src_buf_d = src_buf_q;
    line_d    = line_q;
    if (commit_i.valid) begin
      case (commit_i.item.op)
        OP_RESTART: line_d = cfg_i.start_line;
        OP_SRC: begin
          if (cfg_i.mode_src_rev) begin
            src_buf_d = {commit_i.item.data_word, src_buf_q[BufW-1:DataW]};
          end else begin
            src_buf_d = {src_buf_q[DataW-1:0], commit_i.item.data_word};
          end
        end
        OP_END_LINE: begin
          if (cfg_i.mode_ht_dec) begin
            line_d = line_q - LineW'(1);
          end else begin
            line_d = line_q + LineW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q   <= '0;
      src_buf_q <= '0;
      line_q    <= '0;
    end else begin
      src_buf_q <= src_buf_d;
      line_q    <= line_d;
      if (commit_i.valid && commit_i.item.op == OP_LOAD_HT) begin
        table_q[commit_i.item.table_index] <= commit_i.item.data_word;
      end
    end
  end

  assign table_o     = table_q;
  assign src_buf_o   = src_buf_q;
  assign line_o      = line_q;
  assign line_next_o = line_d;

endmodule

// ===== rtl/bbw_combine.sv =====
// Word combine logic: skew, halftone select, halftone op, logic op, end mask.
// Purely combinational. Depends on bbw_pkg.
`timescale 1ns / 1ps

module bbw_combine import bbw_pkg::*; (
  input  cfg_t             cfg_i,
  input  item_t            item_i,
  input  ht_table_t        table_i,
  input  logic [BufW-1:0]  src_buf_i,
  input  logic [LineW-1:0] line_i,
  output logic [DataW-1:0] result_o
);

  logic [BufW-1:0]  skewed;
  logic [DataW-1:0] src, ht, pat, comb, mask, dst;
  logic [IdxW-1:0]  ht_idx;

  assign skewed = src_buf_i >> cfg_i.skew_amount;
  assign src    = skewed[DataW-1:0];
  // smudge picks the entry by the skewed source's low nibble
  assign ht_idx = cfg_i.mode_smudge ? src[IdxW-1:0] : line_i;
  assign ht     = table_i[ht_idx];
  assign dst    = item_i.data_word;

  always_comb begin
    case (hop_e'(cfg_i.halftone_op))
      HOP_ONES:   pat = '1;
      HOP_HT:     pat = ht;
      HOP_SRC:    pat = src;
      default:    pat = src & ht;
    endcase
  end

  // logic op bit3 is s=0,d=0 down to bit0 s=1,d=1
  always_comb begin
    for (int b = 0; b < DataW; b++) begin
      comb[b] = cfg_i.logic_op[~{pat[b], dst[b]}];
    end
  end

  always_comb begin
    case (item_i.position)
      POS_FIRST: mask = cfg_i.mask_first;
      POS_LAST:  mask = cfg_i.mask_last;
      default:   mask = cfg_i.mask_middle;
    endcase
  end

  assign result_o = (item_i.op == OP_DEST) ? ((dst & ~mask) | (comb & mask)) : '0;

endmodule
